FILE: src/lpru_pkg.sv
// Package for the LCD palette register unit: codes, sizes and shade helpers.
package lpru_pkg;

	// Item operation codes.
	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_GLITCH = 2'd3
	} op_t;

	// Bus register addresses.
	localparam logic [2:0] REG_BGP      = 3'd0;
	localparam logic [2:0] REG_OBP0     = 3'd1;
	localparam logic [2:0] REG_OBP1     = 3'd2;
	localparam logic [2:0] REG_BG_INDEX = 3'd3;
	localparam logic [2:0] REG_BG_DATA  = 3'd4;
	localparam logic [2:0] REG_OB_INDEX = 3'd5;
	localparam logic [2:0] REG_OB_DATA  = 3'd6;
	localparam logic [2:0] REG_UNUSED   = 3'd7;

	// Configuration register indexes.
	localparam logic [1:0] CFG_COLOUR_MODE = 2'd0;
	localparam logic [1:0] CFG_DEVICE      = 2'd1;
	localparam logic [1:0] CFG_CONVERSION  = 2'd2;

	// Palette RAM geometry: two byte banks, one for even and one for odd addresses.
	localparam int RAM_BYTES  = 128;
	localparam int BANK_DEPTH = RAM_BYTES / 2;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);

	localparam logic [7:0] INDEX_FORCED = 8'h40;
	localparam logic [7:0] OBJ_RESET_MONO = 8'hFF;
	localparam logic [7:0] OBJ_RESET_COLOUR = 8'h00;
	localparam logic [7:0] READ_OPEN_BUS = 8'hFF;

	// Grey level of a two-bit shade: white, light grey, dark grey, black.
	function automatic logic [7:0] grey_level(input logic [1:0] shade);
		logic [7:0] lvl;
		case (shade)
			2'd0:    lvl = 8'hFF;
			2'd1:    lvl = 8'hAA;
			2'd2:    lvl = 8'h55;
			default: lvl = 8'h00;
		endcase
		return lvl;
	endfunction

	// Picks the shade of one colour number from a monochrome palette byte.
	function automatic logic [7:0] grey_of(input logic [7:0] pal, input logic [1:0] colour);
		logic [1:0] shade;
		case (colour)
			2'd0:    shade = pal[1:0];
			2'd1:    shade = pal[3:2];
			2'd2:    shade = pal[5:4];
			default: shade = pal[7:6];
		endcase
		return grey_level(shade);
	endfunction

	// Steps the low six index bits when auto-increment (bit 7) is set.
	function automatic logic [7:0] bump_index(input logic [7:0] idx);
		logic [7:0] nxt;
		nxt = idx;
		if (idx[7]) begin
			nxt[5:0] = idx[5:0] + 6'd1;
		end
		return nxt;
	endfunction

endpackage

FILE: src/lcd_palette_register_unit.sv
// LCD palette register unit: bus palette registers, palette RAM and colour lookup.
//
// Items arrive on the in channel (op, reg_addr, write_data, color_slot) and
// each gives exactly one result on the out channel (read_data, red, green,
// blue). Register writes and palette RAM writes take effect at the edge that
// accepts the request. The palette RAM is split into an even and an odd byte
// bank so that a colour lookup reads both bytes of a slot in one access.
// A request waits in the lookup stage while the banks deliver their
// registered read data, and moves on to the result register once that is
// free or being taken; out_valid rises as the result register loads. One
// request per cycle is sustained while the receiver keeps out_ready high;
// the single lookup stage and the result register set that figure. When
// the receiver stalls the result register holds, the lookup stage fills,
// and in_ready drops until out_ready returns. The config channel is always
// ready; the user must write it only while the unit is idle, which the block
// itself does not enforce. Reset clears the pipeline, loads the index registers
// with 0x40, the background palettes with zero and the object palettes with
// 0xFF. The palette RAM is not cleared and holds nothing defined until written.
module lcd_palette_register_unit
	import lpru_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// Item request channel.
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [2:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic [5:0] color_slot,
	// Result channel.
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	// Configuration write channel.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data
);

	logic [7:0] ram_even [BANK_DEPTH];
	logic [7:0] ram_odd  [BANK_DEPTH];

	logic colour_mode_q;
	logic colour_device_q;
	logic conversion_q;

	logic [7:0] bg_index_q;
	logic [7:0] ob_index_q;
	logic [7:0] bg_shades_q;
	logic [7:0] prev_bg_shades_q;
	logic [7:0] obj0_shades_q;
	logic [7:0] obj1_shades_q;

	logic               valid_s1;
	op_t                op_s1;
	logic [2:0]         addr_s1;
	logic [5:0]         slot_s1;
	logic               byte_odd_s1;
	logic [7:0]         even_s1;
	logic [7:0]         odd_s1;

	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;

	logic               in_fire;
	logic               advance;
	op_t                op_in;
	logic               colour_access;
	logic               ram_we;
	logic [6:0]         ram_waddr;
	logic [6:0]         data_addr;
	logic [BANK_AW-1:0] ram_raddr;

	logic [7:0] rd_val;
	logic [7:0] red_val;
	logic [7:0] green_val;
	logic [7:0] blue_val;

	// Handshakes: the lookup stage frees up whenever its request moves on.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign op_in     = op_t'(op);

	// Colour-palette registers are reachable only in colour mode.
	assign colour_access = colour_mode_q && (reg_addr != REG_UNUSED);

	// Palette RAM addressing for data accesses and lookups.
	always_comb begin
		if (reg_addr == REG_OB_DATA) begin
			data_addr = {1'b1, ob_index_q[5:0]};
		end else begin
			data_addr = {1'b0, bg_index_q[5:0]};
		end
		ram_waddr = data_addr;
		ram_we    = in_fire && (op_in == OP_WRITE) && colour_access
			&& ((reg_addr == REG_BG_DATA) || (reg_addr == REG_OB_DATA));
		if (op_in == OP_READ) begin
			ram_raddr = data_addr[6:1];
		end else begin
			ram_raddr = color_slot;
		end
	end

	// Palette RAM banks with registered read data.
	always_ff @(posedge clk) begin
		if (ram_we && !ram_waddr[0]) begin
			ram_even[ram_waddr[6:1]] <= write_data;
		end
		if (ram_we && ram_waddr[0]) begin
			ram_odd[ram_waddr[6:1]] <= write_data;
		end
		if (in_fire) begin
			even_s1 <= ram_even[ram_raddr];
			odd_s1  <= ram_odd[ram_raddr];
		end
	end

	// Configuration registers; a device write also reloads the object palettes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_mode_q    <= 1'b0;
			colour_device_q  <= 1'b0;
			conversion_q     <= 1'b0;
			bg_index_q       <= INDEX_FORCED;
			ob_index_q       <= INDEX_FORCED;
			bg_shades_q      <= 8'h00;
			prev_bg_shades_q <= 8'h00;
			obj0_shades_q    <= OBJ_RESET_MONO;
			obj1_shades_q    <= OBJ_RESET_MONO;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COLOUR_MODE: colour_mode_q <= cfg_data;
					CFG_DEVICE: begin
						colour_device_q <= cfg_data;
						obj0_shades_q   <= cfg_data ? OBJ_RESET_COLOUR : OBJ_RESET_MONO;
						obj1_shades_q   <= cfg_data ? OBJ_RESET_COLOUR : OBJ_RESET_MONO;
					end
					CFG_CONVERSION: conversion_q <= cfg_data;
					default: ;
				endcase
			end
			// Bus register writes.
			if (in_fire && (op_in == OP_WRITE)) begin
				unique case (reg_addr)
					REG_BGP: begin
						prev_bg_shades_q <= bg_shades_q;
						bg_shades_q      <= write_data;
					end
					REG_OBP0: obj0_shades_q <= write_data;
					REG_OBP1: obj1_shades_q <= write_data;
					REG_BG_INDEX: begin
						if (colour_access) begin
							bg_index_q <= write_data | INDEX_FORCED;
						end
					end
					REG_BG_DATA: begin
						if (colour_access) begin
							bg_index_q <= bump_index(bg_index_q);
						end
					end
					REG_OB_INDEX: begin
						if (colour_access) begin
							ob_index_q <= write_data | INDEX_FORCED;
						end
					end
					REG_OB_DATA: begin
						if (colour_access) begin
							ob_index_q <= bump_index(ob_index_q);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Lookup stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Lookup stage payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1       <= op_in;
			addr_s1     <= reg_addr;
			slot_s1     <= color_slot;
			byte_odd_s1 <= data_addr[0];
		end
	end

	// Result of the request in the lookup stage.
	always_comb begin
		logic [4:0] r5;
		logic [4:0] g5;
		logic [4:0] b5;
		logic [8:0] mix_r;
		logic [8:0] mix_g;
		logic [8:0] mix_b;
		logic [7:0] grey;

		r5    = even_s1[4:0];
		g5    = {odd_s1[1:0], even_s1[7:5]};
		b5    = odd_s1[6:2];
		// Channel mixing sums stay below 512, so nine bits hold them exactly.
		mix_r = {4'b0, r5} * 9'd13 + {3'b0, g5, 1'b0} + {4'b0, b5};
		mix_g = {4'b0, g5} * 9'd3 + {4'b0, b5};
		mix_b = {4'b0, r5} * 9'd3 + {3'b0, g5, 1'b0} + {4'b0, b5} * 9'd11;
		grey  = 8'h00;

		rd_val    = 8'h00;
		red_val   = 8'h00;
		green_val = 8'h00;
		blue_val  = 8'h00;

		unique case (op_s1)
			OP_READ: begin
				unique case (addr_s1)
					REG_BGP:  rd_val = bg_shades_q;
					REG_OBP0: rd_val = obj0_shades_q;
					REG_OBP1: rd_val = obj1_shades_q;
					REG_BG_INDEX, REG_OB_INDEX, REG_BG_DATA, REG_OB_DATA: begin
						if (!colour_mode_q) begin
							rd_val = READ_OPEN_BUS;
						end else if (addr_s1 == REG_BG_INDEX) begin
							rd_val = bg_index_q;
						end else if (addr_s1 == REG_OB_INDEX) begin
							rd_val = ob_index_q;
						end else begin
							rd_val = byte_odd_s1 ? odd_s1 : even_s1;
						end
					end
					default: rd_val = READ_OPEN_BUS;
				endcase
			end
			OP_WRITE: ;
			OP_LOOKUP: begin
				if (colour_mode_q) begin
					if (conversion_q) begin
						red_val   = mix_r[8:1];
						green_val = {mix_g[6:0], 1'b0};
						blue_val  = mix_b[8:1];
					end else begin
						red_val   = {r5, r5[4:2]};
						green_val = {g5, g5[4:2]};
						blue_val  = {b5, b5[4:2]};
					end
				end else begin
					case (slot_s1[5:2])
						4'd0:    grey = grey_of(bg_shades_q, slot_s1[1:0]);
						4'd1:    grey = grey_of(obj0_shades_q, slot_s1[1:0]);
						4'd2:    grey = grey_of(obj1_shades_q, slot_s1[1:0]);
						default: grey = 8'h00;
					endcase
					red_val   = grey;
					green_val = grey;
					blue_val  = grey;
				end
			end
			OP_GLITCH: begin
				grey      = grey_of(bg_shades_q | prev_bg_shades_q, slot_s1[1:0]);
				red_val   = grey;
				green_val = grey;
				blue_val  = grey;
			end
			default: ;
		endcase
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_val;
			red_q       <= red_val;
			green_q     <= green_val;
			blue_q      <= blue_val;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

endmodule

FILE: test/lpru_palette_checker.sv
// Checker for the LCD palette unit: mirrors its registers and palette RAM and scores every result.
module lpru_palette_checker
	import lpru_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] op,
	input  logic [2:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic [5:0] color_slot,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] read_data,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	output int         fail_count,
	output int         pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_out_t;

	// Mirror of the unit's registers and palette RAM.
	logic [7:0] shadow_ram [RAM_BYTES];
	logic [7:0] bg_index;
	logic [7:0] ob_index;
	logic [7:0] bg_pal;
	logic [7:0] bg_pal_prev;
	logic [7:0] ob0_pal;
	logic [7:0] ob1_pal;
	logic       colour_on;
	logic       mix_on;
	pixel_out_t expected_q[$];

	// Grey ramp entry of one colour number taken from a monochrome palette byte.
	function automatic logic [23:0] grey_rgb(input logic [7:0] pal, input logic [1:0] colour);
		logic [1:0] shade;
		shade = 2'(pal >> {colour, 1'b0});
		case (shade)
			2'd0:    return 24'hFFFFFF;
			2'd1:    return 24'hAAAAAA;
			2'd2:    return 24'h555555;
			default: return 24'h000000;
		endcase
	endfunction

	// Expands an RGB15 value to 24 bits by replication or by channel mixing.
	function automatic logic [23:0] expand_rgb15(input logic [15:0] rgb, input logic mix);
		int r;
		int g;
		int b;
		int rr;
		int gg;
		int bb;
		r = rgb[4:0];
		g = rgb[9:5];
		b = rgb[14:10];
		if (mix) begin
			rr = (13 * r + 2 * g + b) >> 1;
			gg = (3 * g + b) << 1;
			bb = (3 * r + 2 * g + 11 * b) >> 1;
		end else begin
			rr = (r << 3) | (r >> 2);
			gg = (g << 3) | (g >> 2);
			bb = (b << 3) | (b >> 2);
		end
		return {rr[7:0], gg[7:0], bb[7:0]};
	endfunction

	// Auto-increment wraps within the low six bits and only when bit 7 is set.
	function automatic logic [7:0] next_index(input logic [7:0] idx);
		logic [7:0] nxt;
		nxt = idx;
		if (idx[7]) begin
			nxt[5:0] = idx[5:0] + 6'd1;
		end
		return nxt;
	endfunction

	// Applies one request to the mirror and works out the result it must give.
	task automatic predict_request(input op_t o, input logic [2:0] ra, input logic [7:0] wd,
			input logic [5:0] slot, output pixel_out_t res);
		logic [23:0] rgb;
		res = '0;
		rgb = '0;
		case (o)
			OP_READ: begin
				case (ra)
					REG_BGP:  res.read_data = bg_pal;
					REG_OBP0: res.read_data = ob0_pal;
					REG_OBP1: res.read_data = ob1_pal;
					default: begin
						if (!colour_on) begin
							res.read_data = READ_OPEN_BUS;
						end else begin
							case (ra)
								REG_BG_INDEX: res.read_data = bg_index;
								REG_BG_DATA:  res.read_data = shadow_ram[{1'b0, bg_index[5:0]}];
								REG_OB_INDEX: res.read_data = ob_index;
								REG_OB_DATA:  res.read_data = shadow_ram[{1'b1, ob_index[5:0]}];
								default:      res.read_data = READ_OPEN_BUS;
							endcase
						end
					end
				endcase
			end
			OP_WRITE: begin
				case (ra)
					REG_BGP: begin
						bg_pal_prev = bg_pal;
						bg_pal = wd;
					end
					REG_OBP0: ob0_pal = wd;
					REG_OBP1: ob1_pal = wd;
					default: begin
						// Colour palette registers only respond in colour mode.
						if (colour_on) begin
							case (ra)
								REG_BG_INDEX: bg_index = wd | INDEX_FORCED;
								REG_BG_DATA: begin
									shadow_ram[{1'b0, bg_index[5:0]}] = wd;
									bg_index = next_index(bg_index);
								end
								REG_OB_INDEX: ob_index = wd | INDEX_FORCED;
								REG_OB_DATA: begin
									shadow_ram[{1'b1, ob_index[5:0]}] = wd;
									ob_index = next_index(ob_index);
								end
								default: ;
							endcase
						end
					end
				endcase
			end
			OP_LOOKUP: begin
				if (colour_on) begin
					rgb = expand_rgb15({shadow_ram[{slot, 1'b1}], shadow_ram[{slot, 1'b0}]},
						mix_on);
				end else begin
					// Slots past object palette 1 are black.
					case (slot[5:2])
						4'd0:    rgb = grey_rgb(bg_pal, slot[1:0]);
						4'd1:    rgb = grey_rgb(ob0_pal, slot[1:0]);
						4'd2:    rgb = grey_rgb(ob1_pal, slot[1:0]);
						default: rgb = 24'h000000;
					endcase
				end
			end
			default: begin
				// Glitched lookup always uses the grey ramp of both background palettes.
				rgb = grey_rgb(bg_pal | bg_pal_prev, slot[1:0]);
			end
		endcase
		res.red = rgb[23:16];
		res.green = rgb[15:8];
		res.blue = rgb[7:0];
	endtask

	// Watches the three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		pixel_out_t want;
		pixel_out_t got;
		if (!arst_n) begin
			bg_index = INDEX_FORCED;
			ob_index = INDEX_FORCED;
			bg_pal = '0;
			bg_pal_prev = '0;
			ob0_pal = OBJ_RESET_MONO;
			ob1_pal = OBJ_RESET_MONO;
			colour_on = 1'b0;
			mix_on = 1'b0;
			expected_q.delete();
			fail_count = 0;
		end else begin
			// Configuration writes.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COLOUR_MODE: colour_on = cfg_data;
					CFG_DEVICE: begin
						ob0_pal = cfg_data ? OBJ_RESET_COLOUR : OBJ_RESET_MONO;
						ob1_pal = ob0_pal;
					end
					CFG_CONVERSION: mix_on = cfg_data;
					default: ;
				endcase
			end
			// Results are scored against the oldest expectation.
			if (out_valid && out_ready) begin
				got = {read_data, red, green, blue};
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding: %h", got);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (got.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data, got.read_data);
						fail_count++;
					end
					if (got.red !== want.red) begin
						$error("red: expected %h, got %h", want.red, got.red);
						fail_count++;
					end
					if (got.green !== want.green) begin
						$error("green: expected %h, got %h", want.green, got.green);
						fail_count++;
					end
					if (got.blue !== want.blue) begin
						$error("blue: expected %h, got %h", want.blue, got.blue);
						fail_count++;
					end
				end
			end
			// Accepted requests.
			if (in_valid && in_ready) begin
				predict_request(op_t'(op), reg_addr, write_data, color_slot, want);
				expected_q.push_back(want);
			end
		end
		pending_results = expected_q.size();
	end

endmodule

FILE: test/tb_top.sv
// Top of the LCD palette unit testbench: clock, reset, request traffic and the verdict.
module tb_top
	import lpru_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 185;
	localparam int SQUEEZE_CYCLES = 200;
	localparam int CYCLE_LIMIT = 1000000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	op_t        op;
	logic [2:0] reg_addr;
	logic [7:0] write_data;
	logic [5:0] color_slot;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] read_data;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic       cfg_data;
	int         fail_count;
	int         pending_results;
	int         cycle_count;
	bit         sender_gaps;
	bit         squeeze_req;
	bit         squeeze_done;

	lcd_palette_register_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.color_slot (color_slot),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	lpru_palette_checker palette_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.reg_addr        (reg_addr),
		.write_data      (write_data),
		.color_slot      (color_slot),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.read_data       (read_data),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_top: errors");
		$finish;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Bytes lean toward the extremes.
	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Offers one request and holds it until accepted; called and left just after a falling edge.
	task automatic send_item(input op_t o, input logic [2:0] ra, input logic [7:0] wd,
			input logic [5:0] cs);
		int g;
		op = o;
		reg_addr = ra;
		write_data = wd;
		color_slot = cs;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		g = sender_gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Waits until every request has produced its result, plus a margin for the pipeline.
	task automatic drain();
		in_valid = 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_mode(input logic colour, input logic device, input logic mix);
		drain();
		write_cfg(CFG_COLOUR_MODE, colour);
		write_cfg(CFG_DEVICE, device);
		write_cfg(CFG_CONVERSION, mix);
	endtask

	// Random traffic: index set-ups followed by data bursts, plus loose requests.
	task automatic random_traffic(input int n);
		int sent;
		int k;
		logic [2:0] idx_reg;
		logic [7:0] idx_val;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 15) begin
				idx_reg = $urandom_range(0, 1) ? REG_BG_INDEX : REG_OB_INDEX;
				idx_val = rand_byte();
				idx_val[7] = ($urandom_range(0, 4) != 0);
				send_item(OP_WRITE, idx_reg, idx_val, 6'($urandom_range(0, 63)));
				k = $urandom_range(2, 8);
				repeat (k) begin
					send_item(OP_WRITE, idx_reg + 3'd1, rand_byte(), 6'($urandom_range(0, 63)));
				end
				send_item(OP_READ, idx_reg, rand_byte(), 6'($urandom_range(0, 63)));
				sent += k + 2;
			end else begin
				send_item(op_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rand_byte(),
					6'($urandom_range(0, 63)));
				sent++;
			end
		end
	endtask

	// Receiver: random stalls, ready stretches, and one long hold-off on request.
	initial begin : receiver
		int span;
		int held;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeeze_done) begin
				out_ready = 1'b0;
				held = 0;
				while (held < SQUEEZE_CYCLES) begin
					@(negedge clk);
					held++;
				end
				squeeze_done = 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready = 1'b1;
				span = $urandom_range(30, 150);
				repeat (span) @(negedge clk);
			end else begin
				span = gap_len();
				if (span > 0) begin
					out_ready = 1'b0;
					repeat (span) @(negedge clk);
				end
				out_ready = 1'b1;
				span = $urandom_range(1, 8);
				repeat (span) @(negedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		logic cfg_table [RANDOM_PHASES][3];
		cfg_table = '{'{1'b1, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b0},
			'{1'b1, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1}, '{1'b1, 1'b1, 1'b0}};
		sender_gaps = 1'b1;
		squeeze_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_READ;
		reg_addr = REG_BGP;
		write_data = '0;
		color_slot = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_COLOUR_MODE;
		cfg_data = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Monochrome after reset: reset values, open-bus colour registers, ignored writes.
		for (int a = 0; a < 8; a++) begin
			send_item(OP_READ, 3'(a), 8'h00, 6'd0);
		end
		send_item(OP_WRITE, REG_BGP, 8'hE4, 6'd0);
		send_item(OP_WRITE, REG_BGP, 8'h1B, 6'd0);
		send_item(OP_WRITE, REG_OBP1, 8'hA5, 6'd0);
		send_item(OP_WRITE, REG_BG_INDEX, 8'h80, 6'd0);
		send_item(OP_WRITE, REG_OB_DATA, 8'h12, 6'd0);
		send_item(OP_WRITE, REG_UNUSED, 8'hFF, 6'd0);
		send_item(OP_READ, REG_BG_INDEX, 8'h00, 6'd0);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd0);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd5);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd10);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd12);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd63);
		send_item(OP_GLITCH, REG_BGP, 8'h00, 6'd0);
		send_item(OP_GLITCH, REG_BGP, 8'h00, 6'd1);
		send_item(OP_GLITCH, REG_BGP, 8'h00, 6'd2);
		send_item(OP_GLITCH, REG_BGP, 8'h00, 6'd63);

		// Colour mode: fill the whole palette RAM through auto-increment; the object
		// side starts at the last entry so that the index wraps.
		set_mode(1'b1, 1'b1, 1'b0);
		send_item(OP_WRITE, REG_BG_INDEX, 8'h80, 6'd0);
		repeat (64) send_item(OP_WRITE, REG_BG_DATA, rand_byte(), 6'd0);
		send_item(OP_WRITE, REG_OB_INDEX, 8'hBF, 6'd0);
		repeat (64) send_item(OP_WRITE, REG_OB_DATA, rand_byte(), 6'd0);

		// Colour extremes, a write without increment, and index wrap.
		send_item(OP_READ, REG_OBP0, 8'h00, 6'd0);
		send_item(OP_WRITE, REG_BG_INDEX, 8'h80, 6'd0);
		send_item(OP_WRITE, REG_BG_DATA, 8'h00, 6'd0);
		send_item(OP_WRITE, REG_BG_DATA, 8'h00, 6'd0);
		send_item(OP_WRITE, REG_BG_DATA, 8'hFF, 6'd0);
		send_item(OP_WRITE, REG_BG_DATA, 8'hFF, 6'd0);
		send_item(OP_WRITE, REG_BG_INDEX, 8'h04, 6'd0);
		send_item(OP_WRITE, REG_BG_DATA, 8'h11, 6'd0);
		send_item(OP_WRITE, REG_BG_DATA, 8'h22, 6'd0);
		send_item(OP_READ, REG_BG_INDEX, 8'h00, 6'd0);
		send_item(OP_READ, REG_BG_DATA, 8'h00, 6'd0);
		send_item(OP_WRITE, REG_BG_INDEX, 8'hBF, 6'd0);
		send_item(OP_WRITE, REG_BG_DATA, 8'h7C, 6'd0);
		send_item(OP_READ, REG_BG_INDEX, 8'h00, 6'd0);
		send_item(OP_READ, REG_OB_DATA, 8'h00, 6'd0);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd0);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd1);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd63);
		send_item(OP_GLITCH, REG_BGP, 8'h00, 6'd2);
		set_mode(1'b1, 1'b1, 1'b1);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd0);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd1);
		send_item(OP_LOOKUP, REG_BGP, 8'h00, 6'd63);

		// Random phases over a spread of settings; the first one carries the long hold-off.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_mode(cfg_table[p][0], cfg_table[p][1], cfg_table[p][2]);
			sender_gaps = p[0];
			if (p == 0) begin
				squeeze_req = 1'b1;
			end
			random_traffic(PHASE_ITEMS);
		end

		in_valid = 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
